// File: sv/cwp_pkg.sv
`default_nettype none
package cwp_pkg;

  localparam int unsigned TimeW   = 48;
  localparam int unsigned ModW    = 4;
  localparam int unsigned CfgIdxW = 8;

  localparam logic [CfgIdxW-1:0] RegWindowWidth = 8'd0;
  localparam logic [CfgIdxW-1:0] RegStoredDelay = 8'd1;

  localparam logic [TimeW-1:0] WindowWidthReset = 48'd10;
  localparam logic [TimeW-1:0] StoredDelayReset = 48'd0;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;     // capture a new single, start the walk
    logic advance;  // step to the next older entry
    logic emit;     // take the current entry as a pair
    logic finish;   // close the walk, store the single
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic at_end;      // walk stops at the current entry
    logic pair;        // current entry is from another module
    logic pend_valid;  // a pair waits for its last flag
    logic out_free;    // output register can take a pair this cycle
  } status_t;

endpackage
`default_nettype wire

// File: sv/cwp_if.sv
`default_nettype none
interface cwp_in_if;
  logic                        valid;
  logic                        ready;
  logic [cwp_pkg::TimeW-1:0]   arrival_time;
  logic [cwp_pkg::ModW-1:0]    module_req;

  modport source (output valid, output arrival_time, output module_req, input ready);
  modport sink (input valid, input arrival_time, input module_req, output ready);
endinterface

interface cwp_out_if;
  logic                        valid;
  logic                        ready;
  logic [cwp_pkg::TimeW-1:0]   new_time;
  logic [cwp_pkg::ModW-1:0]    new_module;
  logic [cwp_pkg::TimeW-1:0]   partner_time;
  logic [cwp_pkg::ModW-1:0]    partner_module;
  logic                        last_pair;

  modport source (output valid, output new_time, output new_module, output partner_time,
                  output partner_module, output last_pair, input ready);
  modport sink (input valid, input new_time, input new_module, input partner_time,
                input partner_module, input last_pair, output ready);
endinterface

interface cwp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cwp_pkg::CfgIdxW-1:0]   index;
  logic [cwp_pkg::TimeW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: sv/coincidence_window_pairing_top.sv
`default_nettype none
// Takes one single per walk: accepts it while idle, then steps through the window
// entries kept and closes the walk. The walk over the window memory, one read a
// cycle while the output side does not stall, sets the rate. A pair is loaded into
// the output register when the next pair is found or the walk ends.
// Reset clears the window fill, write pointer and handshake state and loads the
// register defaults; the window memory itself is not cleared.
module coincidence_window_pairing_top #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned TIME_BITS    = 48
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cwp_in_if.sink     sing_i,
  cwp_out_if.source  pair_o,
  cwp_cfg_if.sink    cfg_i
);

  cwp_pkg::cmd_t    cmd;
  cwp_pkg::status_t status;

  // registers are only written while idle
  assign cfg_i.ready = sing_i.ready;

  cwp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sing_i.valid),
    .in_ready_o (sing_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cwp_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .TIME_BITS    (TIME_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .arrival_time_i   (sing_i.arrival_time),
    .module_req_i     (sing_i.module_req),
    .cfg_valid_i      (cfg_i.valid && cfg_i.ready),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_valid_o      (pair_o.valid),
    .out_ready_i      (pair_o.ready),
    .new_time_o       (pair_o.new_time),
    .new_module_o     (pair_o.new_module),
    .partner_time_o   (pair_o.partner_time),
    .partner_module_o (pair_o.partner_module),
    .last_pair_o      (pair_o.last_pair)
  );

endmodule
`default_nettype wire

// File: sv/cwp_ctrl.sv
`default_nettype none
module cwp_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire cwp_pkg::status_t status_i,
  output cwp_pkg::cmd_t         cmd_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StWalk;
        end
      end
      StWalk: begin
        priority if (status_i.at_end) begin
          // hold until the pending pair can leave with its last flag
          cmd_o.finish = !status_i.pend_valid || status_i.out_free;
          if (cmd_o.finish) begin
            state_d = StIdle;
          end
        end else if (status_i.pair) begin
          cmd_o.emit    = !status_i.pend_valid || status_i.out_free;
          cmd_o.advance = cmd_o.emit;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/cwp_datapath.sv
`default_nettype none
module cwp_datapath #(
  parameter int unsigned WINDOW_DEPTH = 16,
  parameter int unsigned TIME_BITS    = 48
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cwp_pkg::cmd_t                cmd_i,
  output cwp_pkg::status_t                  status_o,
  input  wire logic [cwp_pkg::TimeW-1:0]    arrival_time_i,
  input  wire logic [cwp_pkg::ModW-1:0]     module_req_i,
  input  wire logic                         cfg_valid_i,
  input  wire logic [cwp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cwp_pkg::TimeW-1:0]    cfg_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [cwp_pkg::TimeW-1:0]         new_time_o,
  output logic [cwp_pkg::ModW-1:0]          new_module_o,
  output logic [cwp_pkg::TimeW-1:0]         partner_time_o,
  output logic [cwp_pkg::ModW-1:0]          partner_module_o,
  output logic                              last_pair_o
);

  localparam int unsigned PtrW = $clog2(WINDOW_DEPTH);
  localparam int unsigned CntW = $clog2(WINDOW_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(WINDOW_DEPTH - 1);
  localparam logic [CntW-1:0] CntLast = CntW'(WINDOW_DEPTH - 1);

  logic [TIME_BITS-1:0]       mem_time [WINDOW_DEPTH];
  logic [cwp_pkg::ModW-1:0]   mem_mod  [WINDOW_DEPTH];

  logic [cwp_pkg::TimeW-1:0]  width_q, delay_q;
  logic [PtrW-1:0]            wr_ptr_q, cur_addr_q, rd_addr;
  logic [CntW-1:0]            fill_q, kept_q;
  logic [TIME_BITS-1:0]       t_q, rd_time_q, pend_time_q, diff;
  logic [cwp_pkg::ModW-1:0]   m_q, rd_mod_q, pend_mod_q;
  logic                       pend_valid_q, out_valid_q, out_load;

  function automatic logic [PtrW-1:0] prev_ptr(input logic [PtrW-1:0] p);
    prev_ptr = (p == '0) ? PtrLast : p - PtrW'(1);
  endfunction

  assign diff = t_q - rd_time_q;

  assign status_o.at_end     = (kept_q == fill_q) || (64'(diff) > 64'(width_q));
  assign status_o.pair       = (rd_mod_q != m_q);
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_load = (cmd_i.emit || cmd_i.finish) && pend_valid_q;

  always_comb begin
    priority if (cmd_i.load) begin
      rd_addr = prev_ptr(wr_ptr_q);
    end else if (cmd_i.advance) begin
      rd_addr = prev_ptr(cur_addr_q);
    end else begin
      rd_addr = cur_addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      mem_time[wr_ptr_q] <= TIME_BITS'(t_q + TIME_BITS'(delay_q));
      mem_mod[wr_ptr_q]  <= m_q;
    end
    rd_time_q <= mem_time[rd_addr];
    rd_mod_q  <= mem_mod[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q      <= cwp_pkg::WindowWidthReset;
      delay_q      <= cwp_pkg::StoredDelayReset;
      wr_ptr_q     <= '0;
      fill_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_index_i == cwp_pkg::RegWindowWidth) begin
        width_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_index_i == cwp_pkg::RegStoredDelay) begin
        delay_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        wr_ptr_q     <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
        fill_q       <= ((kept_q >= CntLast) ? CntLast : kept_q) + CntW'(1);
        pend_valid_q <= 1'b0;
      end else if (cmd_i.emit) begin
        pend_valid_q <= 1'b1;
      end
      out_valid_q <= out_load || (out_valid_q && !out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_addr_q <= rd_addr;
    if (cmd_i.load) begin
      t_q    <= TIME_BITS'(arrival_time_i);
      m_q    <= module_req_i;
      kept_q <= '0;
    end else if (cmd_i.advance) begin
      kept_q <= kept_q + CntW'(1);
    end
    if (cmd_i.emit) begin
      pend_time_q <= rd_time_q;
      pend_mod_q  <= rd_mod_q;
    end
    if (out_load) begin
      new_time_o       <= cwp_pkg::TimeW'(t_q);
      new_module_o     <= m_q;
      partner_time_o   <= cwp_pkg::TimeW'(pend_time_q);
      partner_module_o <= pend_mod_q;
      last_pair_o      <= cmd_i.finish;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire
